### design/delimiter_token_splitter_macros.svh
`ifndef DELIMITER_TOKEN_SPLITTER_MACROS_SVH
`define DELIMITER_TOKEN_SPLITTER_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst is high.
`define DTS_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst is high.
`define DTS_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

### design/dts_pkg.sv
package dts_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SPLIT_MODE   = 2'd0;
  localparam logic [1:0] CFG_DELIM_BYTES  = 2'd1;
  localparam logic [1:0] CFG_DELIM_LENGTH = 2'd2;
  localparam logic [1:0] CFG_DROP_EMPTY   = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [63:0] DELIM_BYTES_RESET  = 64'd44;
  localparam logic [3:0]  DELIM_LENGTH_RESET = 4'd1;

  typedef struct packed {
    logic        split_mode;
    logic [63:0] delimiter_bytes;
    logic [3:0]  delimiter_length;
    logic        drop_empty;
  } cfg_t;

  // Main action of one input character.
  typedef enum logic [1:0] {
    MAIN_NONE = 2'd0,
    MAIN_CHAR = 2'd1,
    MAIN_TEND = 2'd2
  } main_t;

  // Command passed from the front to the back: a prefix flush, the main
  // action, a final prefix flush and an optional string end mark.
  typedef struct packed {
    logic [2:0] pre;
    main_t      main;
    logic [7:0] ch;
    logic [2:0] post;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       tend;
    logic       send;
    logic       run_last;
  } res_t;

  // Picks delimiter character k out of the packed delimiter word.
  function automatic logic [7:0] delim_byte(input logic [63:0] bytes, input logic [2:0] k);
    delim_byte = bytes[{k, 3'b000} +: 8];
  endfunction

endpackage

### design/delimiter_token_splitter.sv
// Results pass the command queue, the back command register and the result queue.
// One result per cycle while the output queue has room; a character with k results
// (0 to 9) holds the back end until all are out, so plain characters stream at one
// per cycle. A four-entry command queue decouples input from the result expander.
// Reset (rst, synchronous): empties both queues, clears match state and loads
// the configuration defaults (sequence mode, delimiter ',', length 1, keep empty).
module delimiter_token_splitter
  import dts_pkg::*;
#(
  parameter int MAX_DELIM_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_in,
  input  logic        string_last,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  char_out,
  output logic        char_valid,
  output logic        token_end,
  output logic        string_end,
  output logic        run_last,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  cfg_t cfg;
  logic accept;
  logic cmd_push;
  cmd_t cmd_new;
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_pop;
  logic res_push;
  res_t res_new;
  res_t res_head;
  logic res_full;
  logic res_room;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.split_mode       <= 1'b0;
      cfg.delimiter_bytes  <= DELIM_BYTES_RESET;
      cfg.delimiter_length <= DELIM_LENGTH_RESET;
      cfg.drop_empty       <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_SPLIT_MODE:   cfg.split_mode       <= cfg_data[0];
        CFG_DELIM_BYTES:  cfg.delimiter_bytes  <= cfg_data;
        CFG_DELIM_LENGTH: cfg.delimiter_length <= cfg_data[3:0];
        CFG_DROP_EMPTY:   cfg.drop_empty       <= cfg_data[0];
        default:          cfg.drop_empty       <= cfg.drop_empty;
      endcase
    end
  end

  // Input transaction.
  assign accept = push && !full;

  dts_front #(
    .MAX_DELIM_CHARS(MAX_DELIM_CHARS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .char_in    (char_in),
    .string_last(string_last),
    .cmd_push   (cmd_push),
    .cmd        (cmd_new)
  );

  dts_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_data(cmd_new),
    .full     (full),
    .pop      (cmd_pop),
    .pop_data (cmd_head),
    .empty    (cmd_empty)
  );

  // The output queue frees a slot in the same cycle a result is taken.
  assign res_room = !res_full || (pop && !empty);

  dts_back u_back (
    .clk            (clk),
    .rst            (rst),
    .delimiter_bytes(cfg.delimiter_bytes),
    .cmd_valid      (!cmd_empty),
    .cmd_in         (cmd_head),
    .cmd_pop        (cmd_pop),
    .res_push       (res_push),
    .res            (res_new),
    .res_room       (res_room)
  );

  dts_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_data(res_new),
    .full     (res_full),
    .pop      (pop),
    .pop_data (res_head),
    .empty    (empty)
  );

  assign char_out   = res_head.ch;
  assign char_valid = res_head.valid;
  assign token_end  = res_head.tend;
  assign string_end = res_head.send;
  assign run_last   = res_head.run_last;

endmodule

### design/dts_fifo.sv
`include "delimiter_token_splitter_macros.svh"

module dts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem [DEPTH];
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  // Status comes from the registered count only.
  assign empty    = (count == '0);
  assign full     = (count == COUNT_W'(DEPTH));
  assign pop_data = mem[rd_ptr];
  assign do_pop   = pop && !empty;
  assign do_push  = push && (!full || do_pop);

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `DTS_ASSERT_NOW(a_count_bound, 1'b1, count <= COUNT_W'(DEPTH), "fifo count exceeds depth")
  `DTS_ASSERT_NEXT(a_count_up, do_push && !do_pop, count == $past(count) + COUNT_W'(1), "fifo count did not grow on push")

endmodule

### design/dts_front.sv
module dts_front
  import dts_pkg::*;
#(
  parameter int MAX_DELIM_CHARS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] char_in,
  input  logic       string_last,
  output logic       cmd_push,
  output cmd_t       cmd
);

  logic [2:0] match_progress;
  logic [2:0] match_progress_next;
  logic       token_has_chars;
  logic       token_has_chars_next;
  logic [3:0] len;
  logic       hit;
  logic [3:0] p;
  logic       has_results;

  // Effective delimiter length, clamped to 1..MAX_DELIM_CHARS.
  always_comb begin
    len = cfg.delimiter_length;
    if (len == 4'd0) begin
      len = 4'd1;
    end
    if (len > 4'(MAX_DELIM_CHARS)) begin
      len = 4'(MAX_DELIM_CHARS);
    end
  end

  // Set mode: compare the character against every delimiter in use.
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if ((4'(k) < len) && (delim_byte(cfg.delimiter_bytes, 3'(k)) == char_in)) begin
        hit = 1'b1;
      end
    end
  end

  // Classify one character into a command and compute the next match state.
  always_comb begin
    cmd.pre              = 3'd0;
    cmd.main             = MAIN_NONE;
    cmd.ch               = char_in;
    cmd.post             = 3'd0;
    cmd.last             = string_last;
    token_has_chars_next = token_has_chars;
    p                    = 4'd0;
    if (cfg.split_mode) begin
      cmd.pre = match_progress;
      if (match_progress != 3'd0) begin
        token_has_chars_next = 1'b1;
      end
      if (hit) begin
        cmd.main             = (!cfg.drop_empty || token_has_chars_next) ? MAIN_TEND : MAIN_NONE;
        token_has_chars_next = 1'b0;
      end else begin
        cmd.main             = MAIN_CHAR;
        token_has_chars_next = 1'b1;
      end
    end else begin
      p = {1'b0, match_progress};
      // A pending prefix that cannot be extended is flushed as text.
      if ((p != 4'd0) && ((p >= len) || (char_in != delim_byte(cfg.delimiter_bytes, p[2:0]))))
      begin
        cmd.pre              = match_progress;
        token_has_chars_next = 1'b1;
        p                    = 4'd0;
      end
      if (char_in == delim_byte(cfg.delimiter_bytes, p[2:0])) begin
        p = p + 4'd1;
        if (p >= len) begin
          cmd.main             = (!cfg.drop_empty || token_has_chars_next) ? MAIN_TEND : MAIN_NONE;
          token_has_chars_next = 1'b0;
          p                    = 4'd0;
        end
      end else begin
        cmd.main             = MAIN_CHAR;
        token_has_chars_next = 1'b1;
      end
    end
    match_progress_next = p[2:0];
    // String end flushes any partial match and closes the string.
    if (string_last) begin
      cmd.post             = match_progress_next;
      match_progress_next  = 3'd0;
      token_has_chars_next = 1'b0;
    end
  end

  // Transactions that only extend a partial match or drop an empty token
  // produce nothing and never enter the queue.
  assign has_results = (cmd.pre != 3'd0) || (cmd.main != MAIN_NONE) || string_last;
  assign cmd_push    = accept && has_results;

  // Match state.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_progress  <= 3'd0;
      token_has_chars <= 1'b0;
    end else if (accept) begin
      match_progress  <= match_progress_next;
      token_has_chars <= token_has_chars_next;
    end
  end

endmodule

### design/dts_back.sv
`include "delimiter_token_splitter_macros.svh"

module dts_back
  import dts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] delimiter_bytes,
  input  logic        cmd_valid,
  input  cmd_t        cmd_in,
  output logic        cmd_pop,
  output logic        res_push,
  output res_t        res,
  input  logic        res_room
);

  cmd_t       cmd;
  logic       busy;
  logic [3:0] step;
  logic [4:0] total;
  logic [4:0] step_w;
  logic [4:0] pre_w;
  logic [4:0] main_w;
  logic [4:0] body_end;
  logic [2:0] post_idx;
  logic       done;

  // Result count of the command in hand.
  assign pre_w    = {2'b00, cmd.pre};
  assign main_w   = (cmd.main != MAIN_NONE) ? 5'd1 : 5'd0;
  assign body_end = pre_w + main_w + {2'b00, cmd.post};
  assign total    = body_end + {4'd0, cmd.last};
  assign step_w   = {1'b0, step};
  assign post_idx = 3'(step_w - pre_w - main_w);

  // Select the result for the current step.
  always_comb begin
    res.ch       = 8'd0;
    res.valid    = 1'b0;
    res.tend     = 1'b0;
    res.send     = 1'b0;
    res.run_last = (step_w == total - 5'd1);
    if (step_w < pre_w) begin
      res.ch    = delim_byte(delimiter_bytes, step[2:0]);
      res.valid = 1'b1;
    end else if ((main_w != 5'd0) && (step_w == pre_w)) begin
      case (cmd.main)
        MAIN_CHAR: begin
          res.ch    = cmd.ch;
          res.valid = 1'b1;
        end
        MAIN_TEND: begin
          res.tend = 1'b1;
        end
        default: begin
          res.tend = 1'b0;
        end
      endcase
    end else if (step_w < body_end) begin
      res.ch    = delim_byte(delimiter_bytes, post_idx);
      res.valid = 1'b1;
    end else begin
      res.tend = 1'b1;
      res.send = 1'b1;
    end
  end

  // One result per cycle while the output has room; the next command is
  // loaded in the cycle that finishes the current one.
  assign res_push = busy && res_room;
  assign done     = res_push && res.run_last;
  assign cmd_pop  = cmd_valid && (!busy || done);

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 4'd0;
    end else if (cmd_pop) begin
      busy <= 1'b1;
      step <= 4'd0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (res_push) begin
      step <= step + 4'd1;
    end
  end

  `DTS_ASSERT_NOW(a_step_in_range, busy, step_w < total, "back step beyond command length")
  `DTS_ASSERT_NOW(a_send_is_last, res_push && res.send, res.run_last, "string end not marked last")

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import dts_pkg::*;

  localparam int MAX_DELIM     = 8;
  localparam int RANDOM_ITEMS  = 450;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;

  // One directed row: a character (optionally with typed-in results) or a register write.
  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [63:0] value;
    logic        last;
    logic [1:0]  n_typed;
    res_t        t0;
    res_t        t1;
  } stim_row_t;

  typedef enum int {POP_ALWAYS, POP_HALF, POP_MOSTLY, POP_SPARSE} pop_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_in = 8'd0;
  logic        string_last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  char_out;
  logic        char_valid;
  logic        token_end;
  logic        string_end;
  logic        run_last;
  logic        cfg_write_en = 1'b0;
  logic [1:0]  cfg_index = CFG_SPLIT_MODE;
  logic [63:0] cfg_data = 64'd0;

  // Predictor copy of the configuration and the match state.
  logic        split_set;
  logic [63:0] delim_word;
  logic [3:0]  delim_len;
  logic        drop_on;
  logic [3:0]  match_cnt;
  logic        tok_open;

  res_t      step_out[$];
  res_t      pending_results[$];
  stim_row_t stim_rows[$];

  int         errors = 0;
  int         cycle_count = 0;
  int         random_items = 0;
  int         burst_left = 1;
  pop_style_t pop_style = POP_ALWAYS;
  int         pop_left = 0;

  delimiter_token_splitter #(.MAX_DELIM_CHARS(MAX_DELIM)) uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .char_in(char_in),
    .string_last(string_last), .empty(empty), .pop(pop), .char_out(char_out),
    .char_valid(char_valid), .token_end(token_end), .string_end(string_end),
    .run_last(run_last), .cfg_write_en(cfg_write_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic res_t tok_res(logic [7:0] ch, logic v, logic te, logic se, logic rl);
    res_t r;
    r.ch = ch;
    r.valid = v;
    r.tend = te;
    r.send = se;
    r.run_last = rl;
    return r;
  endfunction

  function automatic int active_len();
    int l;
    l = delim_len;
    if (l < 1) l = 1;
    if (l > MAX_DELIM) l = MAX_DELIM;
    return l;
  endfunction

  function automatic logic [7:0] delim_char(int k);
    return delim_word[8 * (k % 8) +: 8];
  endfunction

  // A character result marks the open token as non-empty.
  function automatic void emit(logic [7:0] ch, logic v, logic te, logic se);
    step_out.insert(step_out.size(), tok_res(ch, v, te, se, 1'b0));
    if (v) tok_open = 1'b1;
  endfunction

  // A pending partial match goes out as plain text.
  function automatic void flush_match();
    int k;
    for (k = 0; k < int'(match_cnt[2:0]); k++) emit(delim_char(k), 1'b1, 1'b0, 1'b0);
    match_cnt = 4'd0;
  endfunction

  function automatic void end_token();
    if (!drop_on || tok_open) emit(8'd0, 1'b0, 1'b1, 1'b0);
    tok_open = 1'b0;
  endfunction

  // Works out the results of one character into step_out and advances the state.
  function automatic void split_char(logic [7:0] c, logic last);
    int   len, k, p;
    logic hit;
    res_t r;
    step_out.delete();
    len = active_len();
    if (split_set) begin
      if (match_cnt != 4'd0) flush_match();
      hit = 1'b0;
      for (k = 0; k < len; k++) if (delim_char(k) == c) hit = 1'b1;
      if (hit) end_token();
      else emit(c, 1'b1, 1'b0, 1'b0);
    end else begin
      p = match_cnt[2:0];
      // Greedy match: a mismatch flushes the prefix and looks at c afresh.
      if (p > 0 && (p >= len || c != delim_char(p))) begin
        flush_match();
        p = 0;
      end
      if (c == delim_char(p)) begin
        p++;
        if (p >= len) begin
          end_token();
          p = 0;
        end
      end else begin
        emit(c, 1'b1, 1'b0, 1'b0);
      end
      match_cnt = 4'(p % 8);
    end
    if (last) begin
      flush_match();
      emit(8'd0, 1'b0, 1'b1, 1'b1);
      match_cnt = 4'd0;
      tok_open = 1'b0;
    end
    if (step_out.size() > 0) begin
      r = step_out[step_out.size() - 1];
      r.run_last = 1'b1;
      step_out[step_out.size() - 1] = r;
    end
  endfunction

  function automatic void add_char(logic [7:0] c, logic last, logic [1:0] n = 2'd0,
                                   res_t t0 = '0, res_t t1 = '0);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CHAR;
    r.value = {56'd0, c};
    r.last = last;
    r.n_typed = n;
    r.t0 = t0;
    r.t1 = t1;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [63:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.value = val;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  // Random register value, extremes included.
  function automatic logic [63:0] pick_value(logic [1:0] idx);
    logic [63:0] v;
    int          k, l;
    v = 64'd0;
    case (idx)
      CFG_DELIM_BYTES: begin
        case ($urandom_range(0, 5))
          0: v = 64'd0;
          1: v = '1;
          2, 3: for (k = 0; k < 8; k++) v[8 * k +: 8] = 8'(8'h61 + $urandom_range(0, 2));
          default: v = {$urandom, $urandom};
        endcase
      end
      CFG_DELIM_LENGTH: begin
        if ($urandom_range(0, 4) == 0) begin
          l = $urandom_range(8, 15);
          if (l == 8) l = 0;
        end else begin
          l = $urandom_range(1, 8);
        end
        v = 64'(l);
      end
      default: v = 64'($urandom_range(0, 1));
    endcase
    return v;
  endfunction

  // Register write while the block is idle; the predictor follows at once.
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_SPLIT_MODE:   split_set = val[0];
      CFG_DELIM_BYTES:  delim_word = val;
      CFG_DELIM_LENGTH: delim_len = val[3:0];
      CFG_DROP_EMPTY:   drop_on = val[0];
      default: ;
    endcase
  endtask

  // Lower push and let every expected result drain, plus time for silent work.
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One input transaction; typed-in results replace the predicted ones when given.
  task automatic send_char(logic [7:0] c, logic last, logic [1:0] n_typed = 2'd0,
                           res_t t0 = '0, res_t t1 = '0);
    int k;
    @(negedge clk);
    push <= 1'b1;
    char_in <= c;
    string_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    split_char(c, last);
    if (n_typed == 2'd0) begin
      for (k = 0; k < step_out.size(); k++)
        pending_results.insert(pending_results.size(), step_out[k]);
    end else begin
      pending_results.insert(pending_results.size(), t0);
      if (n_typed > 2'd1) pending_results.insert(pending_results.size(), t1);
    end
    // Sender bursts: after a burst, a random gap with push low.
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
  endtask

  // A random string, built mostly around the current delimiter.
  task automatic send_string();
    logic [7:0] chars[$];
    logic [1:0] idx;
    int         n, k, plen;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
    while (chars.size() < n) begin
      if (!split_set && $urandom_range(0, 2) == 0) begin
        // Whole delimiter, or a broken prefix of it.
        plen = active_len();
        if (plen > 1 && $urandom_range(0, 1) == 1) plen = $urandom_range(1, plen - 1);
        for (k = 0; k < plen; k++) chars.insert(chars.size(), delim_char(k));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3:
            chars.insert(chars.size(), delim_char($urandom_range(0, active_len() - 1)));
          4, 5, 6: chars.insert(chars.size(), 8'(8'h61 + $urandom_range(0, 2)));
          default: chars.insert(chars.size(), 8'($urandom_range(0, 255)));
        endcase
      end
    end
    for (k = 0; k < chars.size(); k++) begin
      // Now and then a register changes in the middle of a string.
      if ($urandom_range(0, 29) == 0) begin
        wait_idle();
        idx = 2'($urandom_range(0, 3));
        write_reg(idx, pick_value(idx));
      end
      send_char(chars[k], k == chars.size() - 1);
    end
    random_items += chars.size();
  endtask

  // Receiver stalls on a pattern that is picked anew at random when its run ends.
  always @(negedge clk) begin
    if (pop_left <= 0) begin
      pop_style = pop_style_t'($urandom_range(0, 3));
      pop_left = $urandom_range(8, 40);
    end
    pop_left--;
    case (pop_style)
      POP_ALWAYS: pop <= 1'b1;
      POP_HALF:   pop <= 1'($urandom_range(0, 1));
      POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
      default:    pop <= (pop_left % 6 == 0);
    endcase
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Each accepted result transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual ch=%0h valid=%b te=%b se=%b rl=%b",
                 $time, char_out, char_valid, token_end, string_end, run_last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("char_out", want.ch, char_out);
        check_field("char_valid", want.valid, char_valid);
        check_field("token_end", want.tend, token_end);
        check_field("string_end", want.send, string_end);
        check_field("run_last", want.run_last, run_last);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int        i;
    stim_row_t r;
    split_set = 1'b0;
    delim_word = DELIM_BYTES_RESET;
    delim_len = DELIM_LENGTH_RESET;
    drop_on = 1'b0;
    match_cnt = 4'd0;
    tok_open = 1'b0;

    // Defaults after reset: sequence mode, delimiter ',', keep empty tokens.
    add_char("a", 1'b0, 2'd1, tok_res("a", 1'b1, 1'b0, 1'b0, 1'b1));
    add_char(",", 1'b0, 2'd1, tok_res(8'd0, 1'b0, 1'b1, 1'b0, 1'b1));
    add_char("b", 1'b1, 2'd2, tok_res("b", 1'b1, 1'b0, 1'b0, 1'b0),
             tok_res(8'd0, 1'b0, 1'b1, 1'b1, 1'b1));
    add_char(",", 1'b1, 2'd2, tok_res(8'd0, 1'b0, 1'b1, 1'b0, 1'b0),
             tok_res(8'd0, 1'b0, 1'b1, 1'b1, 1'b1));
    // Dropped empty tokens, while the final token is always emitted.
    add_cfg(CFG_DROP_EMPTY, 64'd1);
    add_char(",", 1'b0);
    add_char(8'h00, 1'b0);
    add_char(",", 1'b0);
    add_char(",", 1'b1);
    add_char(8'hff, 1'b1);
    // Delimiter "aab": greedy matching without backtracking.
    add_cfg(CFG_DROP_EMPTY, 64'd0);
    add_cfg(CFG_DELIM_BYTES, 64'h626161);
    add_cfg(CFG_DELIM_LENGTH, 64'd3);
    add_char("a", 1'b0);
    add_char("a", 1'b0);
    add_char("a", 1'b0);
    add_char("a", 1'b0);
    add_char("b", 1'b0);
    // Partial match flushed at string end.
    add_char("a", 1'b1);
    // Length shrinks under a pending prefix.
    add_char("a", 1'b0);
    add_cfg(CFG_DELIM_LENGTH, 64'd1);
    add_char("x", 1'b0);
    // Switch to set mode under a pending prefix.
    add_cfg(CFG_DELIM_LENGTH, 64'd3);
    add_char("a", 1'b0);
    add_cfg(CFG_SPLIT_MODE, 64'd1);
    add_char("b", 1'b0);
    add_char("z", 1'b1);
    // Length zero acts as one.
    add_cfg(CFG_DELIM_BYTES, '1);
    add_cfg(CFG_DELIM_LENGTH, 64'd0);
    add_char(8'hff, 1'b1);
    // Length above the maximum acts as eight; seven matched then a mismatch at end.
    add_cfg(CFG_DELIM_BYTES, 64'h7171717171717171);
    add_cfg(CFG_DELIM_LENGTH, 64'd15);
    add_cfg(CFG_SPLIT_MODE, 64'd0);
    for (i = 0; i < 7; i++) add_char("q", 1'b0);
    add_char("r", 1'b1);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part.
    for (i = 0; i < stim_rows.size(); i++) begin
      r = stim_rows[i];
      if (r.kind == ROW_CFG) begin
        wait_idle();
        write_reg(r.reg_idx, r.value);
      end else begin
        send_char(r.value[7:0], r.last, r.n_typed, r.t0, r.t1);
      end
    end

    // Random part: phases of random settings, each with a few strings.
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      write_reg(CFG_SPLIT_MODE, pick_value(CFG_SPLIT_MODE));
      write_reg(CFG_DELIM_BYTES, pick_value(CFG_DELIM_BYTES));
      write_reg(CFG_DELIM_LENGTH, pick_value(CFG_DELIM_LENGTH));
      write_reg(CFG_DROP_EMPTY, pick_value(CFG_DROP_EMPTY));
      repeat ($urandom_range(3, 6)) send_string();
    end

    wait_idle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/dts_pkg.sv
design/dts_fifo.sv
design/dts_front.sv
design/dts_back.sv
design/delimiter_token_splitter.sv
tb/tb.sv
